### design/cwn_pkg.sv
// ----------------------------------------------------------------------------
// cwn_pkg: shared types and the Windows-1251 character maps
// Beat structs, the queue entry format and the case fold / simplify tables.
// ----------------------------------------------------------------------------
package cwn_pkg;

  localparam int unsigned QDepth = 4;

  localparam logic [7:0] SpaceByte = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } cwn_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } cwn_out_t;

  // One queue entry: up to three output beats, in this order.
  typedef struct packed {
    logic       lead_space;
    logic       has_letter;
    logic [7:0] letter;
    logic       tail_space;
  } cwn_cmd_t;

  // Lower-case fold.
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'hC0 && c <= 8'hDF)) begin
      r = c + 8'h20;
    end else begin
      unique case (c)
        8'h81: r = 8'h83;
        8'hA3: r = 8'hBC;
        8'hA5: r = 8'hB4;
        8'hA1, 8'hB2, 8'hBD: r = c + 8'h01;
        8'h98, 8'hA0, 8'hAD: r = SpaceByte;
        8'h80, 8'h8A, 8'h8C, 8'h8D, 8'h8E, 8'h8F,
        8'hA8, 8'hAA, 8'hAF: r = c + 8'h10;
        default: r = c;
      endcase
    end
    return r;
  endfunction

  // Simplify to a basic letter or digit; zero marks a non-word byte.
  function automatic logic [7:0] map_word(input logic [7:0] raw);
    logic [7:0] c;
    logic [7:0] r;
    c = fold_lower(raw);
    r = 8'h00;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) || c >= 8'hE0) begin
      r = c;
    end else begin
      unique case (c)
        8'h83, 8'hB4: r = 8'hE3;
        8'hA2:        r = 8'hF3;
        8'hB8:        r = 8'hE5;
        8'hB3, 8'hBF: r = 8'h69;
        8'hBE:        r = 8'h73;
        8'h9A:        r = 8'hEB;
        8'h9C:        r = 8'hED;
        8'h9D:        r = 8'hEA;
        8'h90, 8'h9E: r = 8'h68;
        8'hBA:        r = 8'hFD;
        8'hBC:        r = 8'h6A;
        8'hA9:        r = 8'h63;
        8'hAE:        r = 8'h72;
        8'hB5:        r = 8'h6D;
        default:      r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

### design/cwn_front.sv
// ----------------------------------------------------------------------------
// cwn_front: input stage
// Accepts input beats, maps the byte, tracks word/space state and emits a
// command per beat that produces output.
// ----------------------------------------------------------------------------
module cwn_front import cwn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cwn_in_t  in_data_i,
  output logic     push_o,
  output cwn_cmd_t cmd_o,
  input  logic     full_i
);

  logic       in_string_q, in_string_d;
  logic       last_space_q, last_space_d;
  logic       accept;
  logic       owed;
  logic [7:0] mapped;
  logic       is_word;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign mapped     = map_word(in_data_i.in_byte);
  assign is_word    = (mapped != 8'h00);
  // leading space is always owed at string start
  assign owed       = !in_string_q || last_space_q;

  always_comb begin
    cmd_o.lead_space = is_word && owed;
    cmd_o.has_letter = is_word;
    cmd_o.letter     = mapped;
    cmd_o.tail_space = in_data_i.in_last;
    push_o           = accept && (is_word || in_data_i.in_last);

    in_string_d  = in_string_q;
    last_space_d = last_space_q;
    if (accept) begin
      if (in_data_i.in_last) begin
        in_string_d  = 1'b0;
        last_space_d = 1'b0;
      end else begin
        in_string_d  = 1'b1;
        last_space_d = !is_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q  <= 1'b0;
      last_space_q <= 1'b0;
    end else begin
      in_string_q  <= in_string_d;
      last_space_q <= last_space_d;
    end
  end

endmodule

### design/cwn_queue.sv
// ----------------------------------------------------------------------------
// cwn_queue: command queue
// Small register FIFO between front and back.
// ----------------------------------------------------------------------------
module cwn_queue import cwn_pkg::*; #(
  parameter int unsigned Depth = QDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cwn_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output cwn_cmd_t head_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cwn_cmd_t        mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### design/cwn_back.sv
// ----------------------------------------------------------------------------
// cwn_back: output sequencer
// Walks the head command through its beats into the output register.
// ----------------------------------------------------------------------------
module cwn_back import cwn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  cwn_cmd_t head_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cwn_out_t out_data_o
);

  localparam logic [1:0] PhLead = 2'd0;
  localparam logic [1:0] PhLetter = 2'd1;
  localparam logic [1:0] PhTail = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  cwn_out_t   out_q, out_d;
  logic       advance;
  logic       sel_lead, sel_letter;
  logic       more;

  assign advance = !empty_i && (!out_valid_q || out_ready_i);

  // first beat of the head command not yet sent
  assign sel_lead   = head_i.lead_space && (phase_q == PhLead);
  assign sel_letter = !sel_lead && head_i.has_letter && (phase_q != PhTail);

  always_comb begin
    phase_d     = phase_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    more        = 1'b0;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      priority if (sel_lead) begin
        out_d.out_byte = SpaceByte;
        out_d.out_last = 1'b0;
        more           = head_i.has_letter || head_i.tail_space;
        phase_d        = PhLetter;
      end else if (sel_letter) begin
        out_d.out_byte = head_i.letter;
        out_d.out_last = 1'b0;
        more           = head_i.tail_space;
        phase_d        = PhTail;
      end else begin
        out_d.out_byte = SpaceByte;
        out_d.out_last = 1'b1;
        more           = 1'b0;
      end
      if (!more) begin
        phase_d = PhLead;
      end
    end
  end

  assign pop_o       = advance && !more;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

### design/cp1251_word_normalizer_unit.sv
// ----------------------------------------------------------------------------
// cp1251_word_normalizer_unit: Windows-1251 word normalizer
// Folds case, simplifies letters and collapses non-word runs to one space.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Beat payload
//   --------+-----------+------------------------+--------------------------
//   in      | input     | in_valid_i/in_ready_o  | cwn_in_t  {byte, last}
//   out     | output    | out_valid_o/out_ready_i| cwn_out_t {byte, last}
//
// Cycles: one input beat per cycle while the queue has room. A command leaves
// as one to three output beats, one per cycle from the output register while the
// receiver is ready: a letter with an owed space takes two, a last beat one to three.
// Reset clears the string state, the queue pointers and the output valid.
// Input and output stall independently; the QueueDepth-entry queue and the
// output register absorb backpressure without losing beats.
//
// Structure:
//   front  - maps each byte, tracks start-of-string and owed-space state,
//            pushes a command only for beats that produce output.
//   queue  - register FIFO of commands.
//   back   - steps through lead space, letter and closing space of the head
//            command, one output beat per cycle while the receiver is ready.
//
module cp1251_word_normalizer_unit import cwn_pkg::*; #(
  parameter int unsigned QueueDepth = QDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cwn_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cwn_out_t out_data_o
);

  cwn_cmd_t push_cmd;
  cwn_cmd_t head_cmd;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  cwn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (q_full)
  );

  cwn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  cwn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### test/cp1251_word_normalizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp1251_word_normalizer_unit_tb: self-checking bench for the word normalizer
// Drives Windows-1251 strings one byte per beat and checks every output beat
// against typed results or a local model of the fold, simplify and space-collapse rules.
// ----------------------------------------------------------------------------
module cp1251_word_normalizer_unit_tb import cwn_pkg::*;;

  localparam int USE_MODEL    = -1;   // row has no typed result, predict it
  localparam int RAND_ITEMS   = 440;
  localparam int QUIET_TAIL   = 60;   // last random beats run with no idling
  localparam int PAUSE_AT     = 300;  // sender drains the block here once
  localparam int HOLD_AFTER   = 150;  // output beats seen before the long hold
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    cwn_in_t  beat;
    int       n_typed;
    cwn_out_t typed [3];
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  cwn_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  cwn_out_t out_data_o;

  // Predictor state: a string is open, and a space is owed to the output.
  logic str_open;
  logic space_owed;

  cwn_out_t    pending_chars [$];  // output beats still to come, oldest first
  dir_row_t    dir_rows [$];
  int unsigned err_cnt;
  int unsigned out_beats;
  bit          quiet;              // tail of the run: nobody idles
  bit          hold_active;        // receiver is in its long hold-off

  cp1251_word_normalizer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the character rules
  // --------------------------------------------------------------------------

  // Case fold: ASCII and Cyrillic capitals rise by 0x20; the odd Cyrillic
  // capitals in 0x80..0xBF move to their lower-case codes; NBSP, soft hyphen
  // and the unused 0x98 become plain space.
  function automatic logic [7:0] lower_1251(input logic [7:0] ch);
    logic [7:0] lo;
    lo = ch;
    if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'hC0 && ch <= 8'hDF)) begin
      lo = ch + 8'h20;
    end else begin
      case (ch)
        8'h81: lo = 8'h83;
        8'hA3: lo = 8'hBC;
        8'hA5: lo = 8'hB4;
        8'hA1, 8'hB2, 8'hBD: lo = ch + 8'h01;
        8'h98, 8'hA0, 8'hAD: lo = SpaceByte;
        8'h80, 8'h8A, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'hA8, 8'hAA, 8'hAF: begin
          lo = ch + 8'h10;
        end
        default: lo = ch;
      endcase
    end
    return lo;
  endfunction

  // Simplified letter or digit, zero for a non-word byte.
  function automatic logic [7:0] simplify_1251(input logic [7:0] raw);
    logic [7:0] lo;
    logic [7:0] s;
    lo = lower_1251(raw);
    s  = 8'h00;
    if ((lo >= 8'h30 && lo <= 8'h39) || (lo >= 8'h61 && lo <= 8'h7A) ||
        lo >= 8'hE0) begin
      s = lo;
    end else begin
      case (lo)
        8'h83, 8'hB4: s = 8'hE3;   // ghe with upturn and the Macedonian gje
        8'hA2:        s = 8'hF3;   // short u
        8'hB8:        s = 8'hE5;   // yo to ye
        8'hB3, 8'hBF: s = 8'h69;   // Ukrainian i, yi
        8'hBE:        s = 8'h73;   // dze
        8'h9A:        s = 8'hEB;   // lje
        8'h9C:        s = 8'hED;   // nje
        8'h9D:        s = 8'hEA;   // kje
        8'h90, 8'h9E: s = 8'h68;   // dje, tshe
        8'hBA:        s = 8'hFD;   // Ukrainian ie
        8'hBC:        s = 8'h6A;   // je
        8'hA9:        s = 8'h63;
        8'hAE:        s = 8'h72;
        8'hB5:        s = 8'h6D;
        default:      s = 8'h00;
      endcase
    end
    return s;
  endfunction

  // One input beat -> zero to three output beats. A space is held back until
  // the next letter or the end of the string; the last beat always closes
  // with a space carrying the end mark.
  function automatic void normalize_byte(input cwn_in_t beat,
                                         output cwn_out_t res [3],
                                         output int n);
    logic [7:0] s;
    logic       owed;
    n    = 0;
    res  = '{default: '0};
    owed = str_open ? space_owed : 1'b1;
    s    = simplify_1251(beat.in_byte);
    if (s != 8'h00) begin
      if (owed) begin
        res[n] = '{out_byte: SpaceByte, out_last: 1'b0};
        n++;
      end
      res[n] = '{out_byte: s, out_last: 1'b0};
      n++;
      owed = 1'b0;
    end else begin
      owed = 1'b1;
    end
    if (beat.in_last) begin
      res[n] = '{out_byte: SpaceByte, out_last: 1'b1};
      n++;
      str_open   = 1'b0;
      space_owed = 1'b0;
    end else begin
      str_open   = 1'b1;
      space_owed = owed;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void add_row(input logic [7:0] b, input logic l,
                                  input int n_typed = USE_MODEL,
                                  input cwn_out_t t0 = '0,
                                  input cwn_out_t t1 = '0,
                                  input cwn_out_t t2 = '0);
    dir_row_t row;
    row.beat     = '{in_byte: b, in_last: l};
    row.n_typed  = n_typed;
    row.typed[0] = t0;
    row.typed[1] = t1;
    row.typed[2] = t2;
    dir_rows.push_back(row);
  endfunction

  // Weighted toward real text: letters, Cyrillic, digits and separators,
  // with the odd 0x80..0xBF block and fully random bytes mixed in.
  function automatic logic [7:0] pick_cp1251_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0:    b = 8'h41 + 8'($urandom_range(0, 25));
      1:    b = 8'h61 + 8'($urandom_range(0, 25));
      2, 3: b = 8'hC0 + 8'($urandom_range(0, 63));
      4:    b = 8'h30 + 8'($urandom_range(0, 9));
      5: begin
        case ($urandom_range(0, 7))
          0:       b = 8'h20;
          1:       b = 8'h2C;
          2:       b = 8'h2E;
          3:       b = 8'hA0;
          4:       b = 8'h98;
          5:       b = 8'hAD;
          6:       b = 8'h0A;
          default: b = 8'h00;
        endcase
      end
      6:       b = 8'h80 + 8'($urandom_range(0, 63));
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Offer one beat, hold it until accepted, then log what it should produce.
  task automatic offer_beat(input dir_row_t row);
    cwn_out_t res [3];
    int       n;
    in_data_i  <= row.beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    normalize_byte(row.beat, res, n);
    if (row.n_typed != USE_MODEL) begin
      n   = row.n_typed;
      res = row.typed;
    end
    for (int k = 0; k < n; k++) pending_chars.push_back(res[k]);
    // Random sender gap, never during the long hold so the block fills up.
    if (!quiet && !hold_active && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output check: each accepted beat against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : out_check
    cwn_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_beats++;
      if (pending_chars.size() == 0) begin
        $error("unexpected output beat: out_byte %h out_last %b",
               out_data_o.out_byte, out_data_o.out_last);
        err_cnt++;
      end else begin
        want = pending_chars.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data_o.out_byte);
          err_cnt++;
        end
        if (out_data_o.out_last !== want.out_last) begin
          $error("out_last: expected %b, got %b", want.out_last, out_data_o.out_last);
          err_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off, always ready at the end
  // --------------------------------------------------------------------------
  initial begin : rx_side
    int   stall;
    int   hold;
    bit   hold_done;
    logic rdy;
    stall     = 0;
    hold      = 0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!hold_done && out_beats >= HOLD_AFTER) begin
        hold        = HOLD_CYCLES;
        hold_done   = 1'b1;
        hold_active = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        rdy = 1'b0;
        if (hold == 0) hold_active = 1'b0;
      end else if (quiet) begin
        rdy = 1'b1;
      end else if (stall > 0) begin
        stall--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11) - 1;   // this cycle is the first of the burst
        rdy   = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready_i <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles with no beat moving on either side
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    dir_row_t row;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    rst_ni      <= 1'b0;
    str_open    = 1'b0;
    space_owed  = 1'b0;
    err_cnt     = 0;
    out_beats   = 0;
    quiet       = 1'b0;
    hold_active = 1'b0;

    // Directed rows. Typed results where obvious, the rest from the model.
    // First byte after reset opens with the leading space.
    add_row(8'h41, 1'b0, 2, '{8'h20, 1'b0}, '{8'h61, 1'b0});
    // Zero byte is a plain non-word byte: nothing out, space owed.
    add_row(8'h00, 1'b0, 0);
    add_row(8'hFF, 1'b0, 2, '{8'h20, 1'b0}, '{8'hFF, 1'b0});
    // Letter on the last byte, closing space carries the end mark.
    add_row(8'h5A, 1'b1, 2, '{8'h7A, 1'b0}, '{8'h20, 1'b1});
    // One-byte string of a non-word byte collapses to a single space.
    add_row(8'h00, 1'b1, 1, '{8'h20, 1'b1});
    // One-byte word string: all three beats.
    add_row(8'h30, 1'b1, 3, '{8'h20, 1'b0}, '{8'h30, 1'b0}, '{8'h20, 1'b1});
    add_row(8'hC0, 1'b0, 2, '{8'h20, 1'b0}, '{8'hE0, 1'b0});
    add_row(8'hDF, 1'b0, 1, '{8'hFF, 1'b0});
    add_row(8'h20, 1'b0, 0);
    add_row(8'hA0, 1'b0, 0);
    // Remapped letters and the space-like bytes.
    add_row(8'hB8, 1'b0);
    add_row(8'hA8, 1'b0);
    add_row(8'h98, 1'b0);
    add_row(8'hAD, 1'b0);
    add_row(8'hBC, 1'b0);
    add_row(8'hA3, 1'b0);
    add_row(8'h81, 1'b0);
    add_row(8'hA5, 1'b0);
    add_row(8'hA1, 1'b0);
    add_row(8'hB2, 1'b0);
    add_row(8'hBD, 1'b0);
    add_row(8'h8A, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'hAA, 1'b0);
    // Non-word last byte after a letter: just the closing space.
    add_row(8'h7F, 1'b1, 1, '{8'h20, 1'b1});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) offer_beat(dir_rows[i]);

    // Random strings, mostly text-like, about one in eight beats ends one.
    row.n_typed = USE_MODEL;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      if (i == PAUSE_AT) begin
        // Let the block run completely dry once.
        if (in_valid_i) in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_chars.size() != 0);
      end
      row.beat.in_byte = pick_cp1251_byte();
      row.beat.in_last = ($urandom_range(0, 7) == 0);
      offer_beat(row);
    end
    if (in_valid_i) in_valid_i <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
design/cwn_pkg.sv
design/cwn_front.sv
design/cwn_queue.sv
design/cwn_back.sv
design/cp1251_word_normalizer_unit.sv
test/cp1251_word_normalizer_unit_tb.sv
